[rtl/hht_pkg.sv]
// types, result kinds and byte classes for the http header tokenizer
// no dependencies; imported by http_header_tokenizer and the testbench
package hht_pkg;

    typedef enum logic [2:0] {
        KIND_WORD_CHAR  = 3'd0,
        KIND_WORD_END   = 3'd1,
        KIND_SEPARATOR  = 3'd2,
        KIND_LINE_END   = 3'd3,
        KIND_TERMINATE  = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // one result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_value;
        logic       first_char;
        logic       last;
    } result_t;

    // separator set: ( ) < > @ , ; : \ " / [ ] ? = { } plus control bytes
    function automatic logic is_separator(input logic [7:0] b);
        logic hit;
        hit = b inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
                        8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B,
                        8'h7D};
        return hit || (b < 8'h20) || (b == CHAR_DEL);
    endfunction

endpackage

[rtl/http_header_tokenizer.sv]
// http header tokenizer: splits header bytes into word, separator, line-end, terminate and error items
// depends on hht_pkg for result kinds, the result struct and the separator class
//
// usage
//   s_axis carries one header byte per item in tdata; tlast set marks end of
//   the header text (the byte is then ignored)
//   m_axis carries result items: tuser holds the kind, tdata the character and
//   the first-of-word flag, tlast marks the final result of an input item
//   an input byte gives zero, one or two results (spaces, tabs and a cr/lf
//   outside a word give none; a word end before a separator or terminate
//   gives two)
// path: an accepted byte is held in the input register, then its results in the result pair
// throughput: one item per cycle while each byte gives at most one result and m_axis_tready
//   stays high; a byte with two results holds the result pair until the single output port
//   has drained both, and no new byte moves into the pair meanwhile
// reset: rst_n clears the input register valid flag, the result pair count and the word /
//   line-end state; the block then waits for the first byte
// stall: while m_axis_tready is low the result pair holds, the input register
//   fills, and s_axis_tready drops until the pair can be refilled
module http_header_tokenizer
    import hht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // char_value [7:0], first_char [8], zero fill
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    // lexer state
    logic in_word_reg, in_word_next;
    logic pend_reg, pend_next;
    logic pend_cr_reg, pend_cr_next;

    // result pair: head is on the port, tail follows it
    logic [1:0] pr_count_reg, pr_count_next;
    result_t    pr_head_reg, pr_head_next;
    result_t    pr_tail_reg, pr_tail_next;

    // decode of the registered byte
    result_t    res [2];
    logic [1:0] res_n;
    logic       pair_free;
    logic       move;
    logic       out_take;
    logic       is_delim;
    logic       is_blank;
    logic       is_crlf;

    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign pair_free = (pr_count_reg == 2'd0) || ((pr_count_reg == 2'd1) && m_axis_tready);
    assign move      = in_valid_reg && pair_free;
    assign s_axis_tready = !in_valid_reg || move;

    assign is_blank = (in_byte_reg == CHAR_SPACE) || (in_byte_reg == CHAR_TAB);
    assign is_crlf  = (in_byte_reg == CHAR_CR) || (in_byte_reg == CHAR_LF);
    assign is_delim = is_blank || is_crlf || is_separator(in_byte_reg);

    // one pass over the registered byte: results and next lexer state
    always_comb
    begin
        result_t blank_res;
        blank_res    = '{kind: KIND_WORD_CHAR, char_value: 8'h00, first_char: 1'b0,
                         last: 1'b0};
        res[0]       = blank_res;
        res[1]       = blank_res;
        res_n        = 2'd0;
        in_word_next = in_word_reg;
        pend_next    = pend_reg;
        pend_cr_next = pend_cr_reg;

        if (in_eoi_reg)
        begin
            // word end only if a word is still open, then terminate
            if (!pend_reg && in_word_reg)
            begin
                res[0].kind = KIND_WORD_END;
                res[1].kind = KIND_TERMINATE;
                res_n       = 2'd2;
            end
            else
            begin
                res[0].kind = KIND_TERMINATE;
                res_n       = 2'd1;
            end
            in_word_next = 1'b0;
            pend_next    = 1'b0;
            pend_cr_next = 1'b0;
        end
        else if (pend_reg)
        begin
            // only cr followed by lf closes a line; anything else is an error
            res[0].kind  = (pend_cr_reg && (in_byte_reg == CHAR_LF)) ? KIND_LINE_END
                                                                      : KIND_ERROR;
            res_n        = 2'd1;
            in_word_next = 1'b0;
            pend_next    = 1'b0;
            pend_cr_next = 1'b0;
        end
        else if (is_delim)
        begin
            if (in_word_reg)
            begin
                res[0].kind  = KIND_WORD_END;
                res_n        = 2'd1;
                in_word_next = 1'b0;
            end
            if (is_crlf)
            begin
                pend_next    = 1'b1;
                pend_cr_next = (in_byte_reg == CHAR_CR);
            end
            else if (!is_blank)
            begin
                res[res_n[0]].kind       = KIND_SEPARATOR;
                res[res_n[0]].char_value = in_byte_reg;
                res_n                    = res_n + 2'd1;
            end
        end
        else
        begin
            // word character, including bytes 128..255
            res[0].kind       = KIND_WORD_CHAR;
            res[0].char_value = in_byte_reg;
            res[0].first_char = !in_word_reg;
            res_n             = 2'd1;
            in_word_next      = 1'b1;
        end

        if (res_n == 2'd2)
        begin
            res[1].last = 1'b1;
        end
        else
        begin
            res[0].last = 1'b1;
        end
    end

    // next values of the input register and the result pair
    always_comb
    begin
        in_valid_next = in_valid_reg;
        pr_count_next = pr_count_reg;
        pr_head_next  = pr_head_reg;
        pr_tail_next  = pr_tail_reg;

        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end

        if (move)
        begin
            pr_count_next = res_n;
            pr_head_next  = res[0];
            pr_tail_next  = res[1];
        end
        else if (out_take)
        begin
            pr_count_next = pr_count_reg - 2'd1;
            pr_head_next  = pr_tail_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pr_count_reg <= 2'd0;
            in_word_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            pend_cr_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pr_count_reg <= pr_count_next;
            if (move)
            begin
                in_word_reg <= in_word_next;
                pend_reg    <= pend_next;
                pend_cr_reg <= pend_cr_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
        pr_head_reg <= pr_head_next;
        pr_tail_reg <= pr_tail_next;
    end

    assign m_axis_tvalid = (pr_count_reg != 2'd0);
    assign m_axis_tuser  = pr_head_reg.kind;
    assign m_axis_tdata  = {7'b0, pr_head_reg.first_char, pr_head_reg.char_value};
    assign m_axis_tlast  = pr_head_reg.last;

    // the result pair never holds more than two items
    assert property (@(posedge clk) disable iff (!rst_n) pr_count_reg != 2'd3)
        else $error("result pair overfilled");

    // the head carries the item mark exactly when it is the only result left
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (pr_count_reg == 2'd1)))
        else $error("tlast out of step with result pair");

    // terminate and error always close an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_TERMINATE || m_axis_tuser == KIND_ERROR))
        |-> m_axis_tlast)
        else $error("terminate or error not last");

    // a taken pending line end leaves no word open
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> !in_word_reg)
        else $error("word open with line end pending");

endmodule

[tb/testbench.sv]
// self-checking testbench for http_header_tokenizer: streams header bytes and
// end-of-input marks in, predicts the token results and checks each one
// depends on hht_pkg (result kinds, result struct, character constants) and the rtl
`timescale 1ns / 1ps

module testbench
    import hht_pkg::*;
();

    localparam int unsigned RANDOM_ITEMS = 1150;
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned HOLD_AFTER   = 400;   // results seen before the hold starts
    localparam int unsigned IDLE_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned MAX_PRINTS   = 200;

    localparam logic [7:0] SEP_SET [17] = '{"(", ")", "<", ">", "@", ",", ";", ":",
                                             "\\", "\"", "/", "[", "]", "?", "=",
                                             "{", "}"};

    // one input item: a header byte or an end-of-input mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } header_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // data_byte
    logic        s_axis_tlast = 1'b0;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // char_value [7:0], first_char [8], zero fill
    logic [2:0]  m_axis_tuser;          // kind
    logic        m_axis_tlast;          // last

    header_item_t header_items[$];      // items still to be offered
    result_t      expected_results[$];  // token results awaiting the output side

    // predictor state
    logic tok_in_word;
    logic tok_line_end_pending;
    logic tok_pending_cr;

    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned kind_seen [6];
    int unsigned idle_cycles = 0;

    // sender and receiver pacing
    int unsigned tx_gap_left;
    int unsigned tx_steady;
    int unsigned rx_gap_left;
    int unsigned rx_steady;
    int unsigned hold_left;
    logic        hold_done;
    logic        tx_next_valid;
    logic        rx_next_ready;
    header_item_t tx_item;
    result_t     got_result;
    result_t     want_result;

    http_header_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // byte classes and token prediction
    // ------------------------------------------------------------------

    // rfc 1945 separators except space, plus control bytes and del
    function automatic logic sep_char(input logic [7:0] b);
        logic hit;
        hit = (b < 8'h20) || (b == CHAR_DEL);
        for (int i = 0; i < 17; i++)
            if (b == SEP_SET[i])
                hit = 1'b1;
        return hit;
    endfunction

    // works out the results of one accepted item and queues them, last marked
    task automatic predict_tokens(input logic [7:0] b, input logic eoi);
        result_t step_out [2];
        int      n;
        n = 0;
        if (eoi) begin
            // a pending line end swallows the word end, which was already given
            if (!tok_line_end_pending && tok_in_word) begin
                step_out[n] = '{KIND_WORD_END, 8'd0, 1'b0, 1'b0};
                n++;
            end
            step_out[n] = '{KIND_TERMINATE, 8'd0, 1'b0, 1'b0};
            n++;
            tok_in_word = 1'b0;
            tok_line_end_pending = 1'b0;
            tok_pending_cr = 1'b0;
        end else if (tok_line_end_pending) begin
            // only cr followed by lf makes a line end; anything else is an error
            if (tok_pending_cr && b == CHAR_LF)
                step_out[n] = '{KIND_LINE_END, 8'd0, 1'b0, 1'b0};
            else
                step_out[n] = '{KIND_ERROR, 8'd0, 1'b0, 1'b0};
            n++;
            tok_in_word = 1'b0;
            tok_line_end_pending = 1'b0;
            tok_pending_cr = 1'b0;
        end else if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF
                     || sep_char(b)) begin
            if (tok_in_word) begin
                step_out[n] = '{KIND_WORD_END, 8'd0, 1'b0, 1'b0};
                n++;
                tok_in_word = 1'b0;
            end
            if (b == CHAR_CR || b == CHAR_LF) begin
                tok_line_end_pending = 1'b1;
                tok_pending_cr = (b == CHAR_CR);
            end else if (b != CHAR_SPACE && b != CHAR_TAB) begin
                step_out[n] = '{KIND_SEPARATOR, b, 1'b0, 1'b0};
                n++;
            end
        end else begin
            // word character, high bytes included
            step_out[n] = '{KIND_WORD_CHAR, b, !tok_in_word, 1'b0};
            n++;
            tok_in_word = 1'b1;
        end
        if (n > 0)
            step_out[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(step_out[i]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch in %0s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
    endtask

    // mostly no gap, often a short one, now and then a long one; steady
    // stretches with no gap at all come in between
    function automatic int unsigned pick_gap(inout int unsigned steady);
        int unsigned r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            steady = $urandom_range(20, 80);
            return 0;
        end
        if (r < 64)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        header_items.push_back('{b, 1'b0});
    endtask

    // the byte beside an end-of-input mark is random and must be ignored
    task automatic push_end();
        header_items.push_back('{8'($urandom_range(0, 255)), 1'b1});
    endtask

    function automatic logic [7:0] pick_word_char();
        logic [7:0] b;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(128, 255));
        do
            b = 8'($urandom_range(33, 126));
        while (sep_char(b));
        return b;
    endfunction

    task automatic push_word(input int unsigned len);
        for (int i = 0; i < len; i++)
            push_byte(pick_word_char());
    endtask

    // one well-formed header block: name ":" value crlf lines, then an ending
    task automatic push_header_block();
        int unsigned lines;
        int unsigned tokens;
        int unsigned r;
        lines = $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
            push_word($urandom_range(1, 8));
            push_byte(":");
            if ($urandom_range(0, 1))
                push_byte(CHAR_SPACE);
            tokens = $urandom_range(1, 5);
            for (int t = 0; t < tokens; t++) begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    push_word($urandom_range(1, 6));
                else if (r < 8)
                    push_byte(SEP_SET[$urandom_range(0, 16)]);
                else
                    push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            end
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
        end
        r = $urandom_range(0, 9);
        if (r < 8) begin
            // blank line closes the header
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
        end else if (r < 9) begin
            // input ends inside a word
            push_word($urandom_range(1, 4));
        end else begin
            // input ends on a bare cr
            push_byte(CHAR_CR);
        end
        push_end();
    endtask

    // ------------------------------------------------------------------
    // sender: offers queued items, predicts on each accepted item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'd0;
            s_axis_tlast  <= 1'b0;
            tx_gap_left = 0;
            tx_steady = 0;
            tok_in_word = 1'b0;
            tok_line_end_pending = 1'b0;
            tok_pending_cr = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_tokens(s_axis_tdata, s_axis_tlast);
                items_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                tx_next_valid = 1'b1;      // item still on offer, hold it
            else if (tx_gap_left > 0)
            begin
                tx_gap_left--;
                tx_next_valid = 1'b0;
            end
            else if (header_items.size() > 0)
            begin
                tx_item = header_items.pop_front();
                s_axis_tdata <= tx_item.data_byte;
                s_axis_tlast <= tx_item.end_of_input;
                tx_next_valid = 1'b1;
                tx_gap_left = pick_gap(tx_steady);
            end
            else
                tx_next_valid = 1'b0;
            s_axis_tvalid <= tx_next_valid;
        end
    end

    // ------------------------------------------------------------------
    // receiver: checks each result, paces tready, one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap_left = 0;
            rx_steady = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_result.kind       = kind_t'(m_axis_tuser);
                got_result.char_value = m_axis_tdata[7:0];
                got_result.first_char = m_axis_tdata[8];
                got_result.last       = m_axis_tlast;
                if (m_axis_tuser <= KIND_ERROR)
                    kind_seen[m_axis_tuser]++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected, kind", m_axis_tuser, -1);
                else
                begin
                    want_result = expected_results.pop_front();
                    if (m_axis_tuser !== want_result.kind)
                        report_mismatch("kind", m_axis_tuser, want_result.kind);
                    if (got_result.char_value !== want_result.char_value)
                        report_mismatch("char_value", got_result.char_value,
                                        want_result.char_value);
                    if (got_result.first_char !== want_result.first_char)
                        report_mismatch("first_char", got_result.first_char,
                                        want_result.first_char);
                    if (m_axis_tdata[15:9] !== 7'd0)
                        report_mismatch("tdata fill bits", m_axis_tdata[15:9], 0);
                    if (got_result.last !== want_result.last)
                        report_mismatch("last", got_result.last, want_result.last);
                end
                results_seen++;
            end
            // once, mid-run, stop taking results so the block backs up
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rx_next_ready = 1'b0;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                rx_next_ready = 1'b0;
            end
            else
            begin
                rx_next_ready = 1'b1;
                rx_gap_left = pick_gap(rx_steady);
            end
            m_axis_tready <= rx_next_ready;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no handshake on either side ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned target;
        int unsigned r;
        int unsigned n;

        // directed part: field extremes and each special case
        push_byte("G");          // word start
        push_byte(8'hFF);        // high bytes are word characters
        push_byte(8'h80);
        push_byte(CHAR_SPACE);   // word end, blank dropped
        push_byte(CHAR_TAB);     // blank outside a word: nothing
        push_byte(8'h00);        // control byte is a separator
        push_byte(CHAR_DEL);
        push_byte("(");
        push_byte("a");
        push_byte("\"");         // word end then separator in one step
        push_byte("b");
        push_byte(CHAR_CR);      // line-end byte inside a word: word end now
        push_byte(CHAR_LF);      // cr lf gives one line end
        push_byte(CHAR_LF);      // bare lf pending ...
        push_byte("x");          // ... then any byte is an error
        push_byte(CHAR_CR);
        push_byte(":");          // cr then not lf: error, byte consumed
        push_byte("h");
        push_end();              // end inside a word: word end and terminate
        push_byte(CHAR_CR);
        push_end();              // end with pending cr: terminate only
        push_byte(CHAR_LF);
        push_end();              // end with pending lf: terminate only
        push_end();              // plain end of input
        push_byte("\\");

        // random part: mostly well-formed headers, the rest noise and bad line ends
        target = header_items.size() + RANDOM_ITEMS;
        while (header_items.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                push_header_block();
            else if (r < 88)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 9) == 0)
                        push_end();
                    else
                        push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    push_word($urandom_range(1, 4));
                push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                if ($urandom_range(0, 3) == 0)
                    push_end();
                else
                    push_byte(8'($urandom_range(0, 255)));
            end
        end

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all items taken and every predicted result seen
        while (header_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d input items and %0d results: %0d word chars, %0d word ends,",
                 items_sent, results_seen, kind_seen[KIND_WORD_CHAR], kind_seen[KIND_WORD_END]);
        $display("%0d separators, %0d line ends, %0d terminates, %0d errors, one %0d-cycle hold",
                 kind_seen[KIND_SEPARATOR], kind_seen[KIND_LINE_END],
                 kind_seen[KIND_TERMINATE], kind_seen[KIND_ERROR], HOLD_CYCLES);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
